@@ rtl/core/bellman_ford_negative_cycle_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Bellman-Ford core
// Implication and invariant checks, clocked on clk, masked during reset.
// ---------------------------------------------------------------------------
`ifndef BELLMAN_FORD_NEGATIVE_CYCLE_CORE_ASSERT_SVH
`define BELLMAN_FORD_NEGATIVE_CYCLE_CORE_ASSERT_SVH

// antecedent true -> consequent true in the same cycle
`define BFNC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every sampled edge out of reset
`define BFNC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

@@ rtl/core/bfnc_pkg.sv @@
// ---------------------------------------------------------------------------
// bfnc_pkg
// Shared types and constants of the Bellman-Ford negative-cycle core.
// ---------------------------------------------------------------------------
`default_nettype none

package bfnc_pkg;

    localparam int MAX_EDGES_DEF    = 128;
    localparam int MAX_VERTICES_DEF = 63;

    localparam int FW = 6;   // vertex field width
    localparam int WW = 16;  // edge weight width
    localparam int DW = 32;  // distance width

    localparam logic signed [DW-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] INT_MIN = 32'sh8000_0000;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [FW-1:0]        edge_from;
        logic [FW-1:0]        edge_to;
        logic signed [WW-1:0] edge_weight;
        logic [FW-1:0]        source_vertex;
    } cmd_t;

    typedef struct packed {
        logic [FW-1:0]        vertex;
        logic signed [DW-1:0] distance;
        logic                 reachable;
        logic [FW-1:0]        predecessor;
        logic                 neg_cycle;
        logic [FW-1:0]        cycle_vertex;
        logic                 last;
    } res_t;

    // one stored edge
    typedef struct packed {
        logic [FW-1:0]        edge_from;
        logic [FW-1:0]        edge_to;
        logic signed [WW-1:0] edge_weight;
    } edge_t;

    // one vertex entry
    typedef struct packed {
        logic                 reached;
        logic [FW-1:0]        pred;
        logic signed [DW-1:0] cost;
    } vtx_t;

    localparam int EDGE_BITS = $bits(edge_t);
    localparam int VTX_BITS  = $bits(vtx_t);

endpackage

`default_nettype wire

@@ rtl/core/bfnc_ram.sv @@
// ---------------------------------------------------------------------------
// bfnc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bfnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];  // read data holds until next read
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/bellman_ford_negative_cycle_core.sv @@
// ---------------------------------------------------------------------------
// bellman_ford_negative_cycle_core
// Edge-list Bellman-Ford with negative-cycle check, one shared relax unit.
// ---------------------------------------------------------------------------
//  channel   | signals                   | handshake
//  ----------+---------------------------+----------------------------------
//  config    | cfg_we, cfg_data          | written on any edge with cfg_we
//  command   | start, busy, cmd          | taken when start & !busy
//  result    | res_strobe, res           | one-cycle strobe per item, no back-pressure
//
//  Clear and add-edge commands are taken without leaving idle. A run
//  sweeps the vertex memory (init), then makes n passes of the relax unit
//  over the E loaded edges (n vertices in use), each edge in an edge read,
//  a vertex read and an add/compare/write step, then reads and emits one
//  result per vertex. Reset clears the edge count and sets num_vertices
//  to 1; memories are not cleared. Results cannot be stalled; busy stays
//  high while a run works.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bellman_ford_negative_cycle_core_assert.svh"

module bellman_ford_negative_cycle_core #(
    parameter int MAX_EDGES    = bfnc_pkg::MAX_EDGES_DEF,
    parameter int MAX_VERTICES = bfnc_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [bfnc_pkg::FW-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire bfnc_pkg::cmd_t        cmd,
    output logic                       res_strobe,
    output bfnc_pkg::res_t             res
);

    import bfnc_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;  // edge address
    localparam int ECW = $clog2(MAX_EDGES + 1);                    // edge count
    localparam int VAW = $clog2(MAX_VERTICES + 1);                 // vertex address
    localparam int CW  = (VAW > FW) ? VAW : FW;                    // compare width

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_EREAD = 7'b0000100,
        ST_VREAD = 7'b0001000,
        ST_EVAL  = 7'b0010000,
        ST_OREAD = 7'b0100000,
        ST_OEMIT = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [FW-1:0]    nv_reg, nv_next;
    logic [ECW-1:0]   edge_count_reg, edge_count_next;
    logic [VAW-1:0]   n_reg, n_next;
    logic [FW-1:0]    src_reg, src_next;
    logic [VAW-1:0]   v_reg, v_next;
    logic [VAW-1:0]   pass_reg, pass_next;
    logic [EAW-1:0]   j_reg, j_next;
    logic             neg_reg, neg_next;
    logic [FW-1:0]    cyc_reg, cyc_next;
    logic             res_strobe_reg, res_strobe_next;
    res_t             res_reg, res_next;

    // memory ports
    logic             e_we, e_re;
    logic [EAW-1:0]   e_waddr;
    edge_t            e_wdata, e_q;
    logic [EDGE_BITS-1:0] e_rdata;
    logic             v_we, va_re, vb_re;
    logic [VAW-1:0]   v_waddr, va_raddr, vb_raddr;
    vtx_t             v_wdata, va_q, vb_q;
    logic [VTX_BITS-1:0] va_rdata, vb_rdata;

    // relax unit
    logic [CW-1:0]    n_ext, a_w, b_w, src_w, nv_w, n_clamp;
    logic             a_ok, b_ok, src_ok, relax;
    logic [DW:0]      sum_wide;
    logic signed [DW-1:0] sum;
    logic             last_edge, cmd_take;

    assign e_q  = edge_t'(e_rdata);
    assign va_q = vtx_t'(va_rdata);
    assign vb_q = vtx_t'(vb_rdata);

    bfnc_ram #(.WIDTH(EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (j_reg),
        .rdata (e_rdata)
    );

    // vertex memory held twice so tail and head read in the same cycle
    bfnc_ram #(.WIDTH(VTX_BITS), .DEPTH(MAX_VERTICES + 1)) u_vtx_ram_a (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (va_re),
        .raddr (va_raddr),
        .rdata (va_rdata)
    );

    bfnc_ram #(.WIDTH(VTX_BITS), .DEPTH(MAX_VERTICES + 1)) u_vtx_ram_b (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (vb_re),
        .raddr (vb_raddr),
        .rdata (vb_rdata)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign cmd_take = start && !busy;

    // vertex range checks against the clamped vertex count
    assign nv_w    = CW'(nv_reg);
    assign n_clamp = (nv_w > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : nv_w;
    assign n_ext   = CW'(n_reg);
    assign a_w     = CW'(e_q.edge_from);
    assign b_w     = CW'(e_q.edge_to);
    assign src_w   = CW'(src_reg);
    assign a_ok    = (a_w != '0) && (a_w <= n_ext);
    assign b_ok    = (b_w != '0) && (b_w <= n_ext);
    assign src_ok  = (src_w != '0) && (src_w <= n_ext);

    // saturating path sum, then the relax compare
    assign sum_wide = {va_q.cost[DW-1], va_q.cost} + (DW+1)'(e_q.edge_weight);
    always_comb
    begin
        if (sum_wide[DW] != sum_wide[DW-1])
        begin
            sum = sum_wide[DW] ? INT_MIN : INT_MAX;
        end
        else
        begin
            sum = sum_wide[DW-1:0];
        end
    end
    assign relax = a_ok && b_ok && va_q.reached && (!vb_q.reached || (sum < vb_q.cost));

    assign last_edge = ((ECW'(j_reg) + ECW'(1)) == edge_count_reg);

    // edge load port
    assign e_we    = cmd_take && (cmd.func == FUNC_ADD) &&
                     (edge_count_reg != ECW'(MAX_EDGES));
    assign e_waddr = EAW'(edge_count_reg);
    assign e_wdata = '{edge_from: cmd.edge_from, edge_to: cmd.edge_to,
                       edge_weight: cmd.edge_weight};
    assign e_re    = (state_reg == ST_EREAD);

    // vertex read ports: tail/head during relax, port A for the result sweep
    assign va_re    = (state_reg == ST_VREAD) || (state_reg == ST_OREAD);
    assign vb_re    = (state_reg == ST_VREAD);
    assign va_raddr = (state_reg == ST_OREAD) ? v_reg : VAW'(e_q.edge_from);
    assign vb_raddr = VAW'(e_q.edge_to);

    // vertex write port: init sweep or a successful relax
    always_comb
    begin
        v_we    = 1'b0;
        v_waddr = v_reg;
        v_wdata = '{reached: 1'b0, pred: '0, cost: INT_MAX};
        if (state_reg == ST_INIT)
        begin
            v_we = 1'b1;
            if (src_ok && (CW'(v_reg) == src_w))
            begin
                v_wdata = '{reached: 1'b1, pred: '0, cost: '0};
            end
        end
        else if ((state_reg == ST_EVAL) && (pass_reg != n_reg) && relax)
        begin
            v_we    = 1'b1;
            v_waddr = VAW'(e_q.edge_to);
            v_wdata = '{reached: 1'b1, pred: e_q.edge_from, cost: sum};
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        nv_next         = nv_reg;
        edge_count_next = edge_count_reg;
        n_next          = n_reg;
        src_next        = src_reg;
        v_next          = v_reg;
        pass_next       = pass_reg;
        j_next          = j_reg;
        neg_next        = neg_reg;
        cyc_next        = cyc_reg;
        res_strobe_next = 1'b0;
        res_next        = res_reg;

        if (cfg_we)
        begin
            nv_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.func)
                        FUNC_CLEAR:
                        begin
                            edge_count_next = '0;
                        end
                        FUNC_ADD:
                        begin
                            if (e_we)
                            begin
                                edge_count_next = edge_count_reg + ECW'(1);
                            end
                        end
                        FUNC_RUN:
                        begin
                            n_next    = VAW'(n_clamp);
                            src_next  = cmd.source_vertex;
                            v_next    = VAW'(1);
                            pass_next = VAW'(1);
                            j_next    = '0;
                            neg_next  = 1'b0;
                            cyc_next  = '0;
                            // no vertices in use: no results at all
                            if (n_clamp != '0)
                            begin
                                state_next = ST_INIT;
                            end
                        end
                        default:
                        begin
                            // reserved code: no effect
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                if (v_reg == n_reg)
                begin
                    v_next     = VAW'(1);
                    state_next = (edge_count_reg == '0) ? ST_OREAD : ST_EREAD;
                end
                else
                begin
                    v_next = v_reg + VAW'(1);
                end
            end
            ST_EREAD:
            begin
                state_next = ST_VREAD;
            end
            ST_VREAD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // final pass only checks; the last violating tail wins
                if ((pass_reg == n_reg) && relax)
                begin
                    neg_next = 1'b1;
                    cyc_next = e_q.edge_from;
                end
                if (last_edge)
                begin
                    j_next = '0;
                    if (pass_reg == n_reg)
                    begin
                        state_next = ST_OREAD;
                    end
                    else
                    begin
                        pass_next  = pass_reg + VAW'(1);
                        state_next = ST_EREAD;
                    end
                end
                else
                begin
                    j_next     = j_reg + EAW'(1);
                    state_next = ST_EREAD;
                end
            end
            ST_OREAD:
            begin
                state_next = ST_OEMIT;
            end
            ST_OEMIT:
            begin
                res_strobe_next       = 1'b1;
                res_next.vertex       = FW'(v_reg);
                res_next.distance     = va_q.reached ? va_q.cost : INT_MAX;
                res_next.reachable    = va_q.reached;
                res_next.predecessor  = va_q.pred;
                res_next.neg_cycle    = neg_reg;
                res_next.cycle_vertex = cyc_reg;
                res_next.last         = (v_reg == n_reg);
                if (v_reg == n_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    v_next     = v_reg + VAW'(1);
                    state_next = ST_OREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nv_reg         <= FW'(1);
            edge_count_reg <= '0;
            n_reg          <= '0;
            src_reg        <= '0;
            v_reg          <= '0;
            pass_reg       <= '0;
            j_reg          <= '0;
            neg_reg        <= 1'b0;
            cyc_reg        <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nv_reg         <= nv_next;
            edge_count_reg <= edge_count_next;
            n_reg          <= n_next;
            src_reg        <= src_next;
            v_reg          <= v_next;
            pass_reg       <= pass_next;
            j_reg          <= j_next;
            neg_reg        <= neg_next;
            cyc_reg        <= cyc_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;

    // checks
    `BFNC_ASSERT_IMPLIES(a_strobe_src, res_strobe_reg, $past(state_reg == ST_OEMIT),
        "result strobe without an emit cycle")
    `BFNC_ASSERT_ALWAYS(a_edge_cap, edge_count_reg <= ECW'(MAX_EDGES),
        "edge count beyond capacity")
    `BFNC_ASSERT_IMPLIES(a_cyc_flag, res_strobe_reg && (res_reg.cycle_vertex != '0),
        res_reg.neg_cycle, "cycle vertex given without negative cycle flag")

endmodule

`default_nettype wire
